>>> hw/rtl/pulse_spo2_window_average_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse / SpO2 window average unit
// Shared property forms; clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_SPO2_WINDOW_AVERAGE_UNIT_DEFINES_SVH
`define PULSE_SPO2_WINDOW_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication
`define PSW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define PSW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Field widths and controller state codes of the window average unit.
// ----------------------------------------------------------------------------
package psw_pkg;

	localparam int PULSE_W = 8;
	localparam int SPO2_W  = 7;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_UPD  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

endpackage

>>> hw/rtl/psw_in_if.sv
// ----------------------------------------------------------------------------
// psw_in_if
// Valid/ready channel carrying one pulse and one SpO2 reading per item.
// ----------------------------------------------------------------------------
interface psw_in_if import psw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_in;
	logic [SPO2_W-1:0]  spo2_in;

	modport source (output valid, output pulse_in, output spo2_in, input ready);
	modport sink   (input valid, input pulse_in, input spo2_in, output ready);
endinterface

>>> hw/rtl/psw_out_if.sv
// ----------------------------------------------------------------------------
// psw_out_if
// Valid/ready channel carrying one pair of window averages per item.
// ----------------------------------------------------------------------------
interface psw_out_if import psw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_avg;
	logic [SPO2_W-1:0]  spo2_avg;

	modport source (output valid, output pulse_avg, output spo2_avg, input ready);
	modport sink   (input valid, input pulse_avg, input spo2_avg, output ready);
endinterface

>>> hw/rtl/psw_ram.sv
// ----------------------------------------------------------------------------
// psw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/psw_div.sv
// ----------------------------------------------------------------------------
// psw_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psw_div #(
	parameter int DW = 12,
	parameter int VW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;

	logic [VW:0]   trial;
	logic          ge;
	logic [VW:0]   diff;
	logic [VW-1:0] rem_next;

	assign trial    = {rem_q, dvd_q[DW-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign diff     = trial - {1'b0, dsr_q};
	assign rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

>>> hw/rtl/pulse_spo2_window_average_unit.sv
// Items are accepted one at a time; ready returns once the result is in the output
// register, later while an earlier result still waits.
// The averages come from two bit-serial dividers, one quotient bit per cycle.
// Reset: sums, fill count, write slot and handshake state clear; ring contents stay
// undefined but are only used once every slot has been written.
// ----------------------------------------------------------------------------
// pulse_spo2_window_average_unit
// Moving average over the last WINDOW pulse / SpO2 pairs with warm-up divisor.
// ----------------------------------------------------------------------------
`include "pulse_spo2_window_average_unit_defines.svh"

module pulse_spo2_window_average_unit import psw_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	psw_in_if.sink     samples,
	psw_out_if.source  averages
);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FC_W   = $clog2(WINDOW + 1);
	localparam int PT_W   = PULSE_W + $clog2(WINDOW);
	localparam int ST_W   = SPO2_W + $clog2(WINDOW);
	localparam int RW     = PULSE_W + SPO2_W;

	state_t             state_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [FC_W-1:0]    fill_q;
	logic [PT_W-1:0]    ptot_q;
	logic [ST_W-1:0]    stot_q;
	logic [PULSE_W-1:0] pin_q;
	logic [SPO2_W-1:0]  sin_q;
	logic               ovalid_q;
	logic [PULSE_W-1:0] pavg_q;
	logic [SPO2_W-1:0]  savg_q;

	logic               accept;
	logic               full;
	logic [RW-1:0]      old_pair;
	logic [PT_W-1:0]    ptot_new;
	logic [ST_W-1:0]    stot_new;
	logic [FC_W-1:0]    fill_new;
	logic [SLOT_W-1:0]  slot_new;
	logic               div_start;
	logic               div_p_done;
	logic               div_s_done;
	logic [PT_W-1:0]    div_p_q;
	logic [PT_W-1:0]    div_s_q;
	logic               load_out;

	assign accept    = samples.valid && samples.ready;
	assign full      = fill_q == FC_W'(WINDOW);
	assign div_start = state_q == S_UPD;
	assign load_out  = (state_q == S_OUT) && (!ovalid_q || averages.ready);

	always_comb begin
		ptot_new = ptot_q + PT_W'(pin_q);
		stot_new = stot_q + ST_W'(sin_q);
		fill_new = fill_q + 1'b1;
		if (full) begin
			ptot_new = ptot_q - PT_W'(old_pair[RW-1:SPO2_W]) + PT_W'(pin_q);
			stot_new = stot_q - ST_W'(old_pair[SPO2_W-1:0]) + ST_W'(sin_q);
			fill_new = fill_q;
		end
		slot_new = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
	end

	psw_ram #(
		.WIDTH (RW),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (div_start),
		.waddr (slot_q),
		.wdata ({pin_q, sin_q}),
		.re    (accept),
		.raddr (slot_q),
		.rdata (old_pair)
	);

	psw_div #(
		.DW (PT_W),
		.VW (FC_W)
	) u_div_pulse (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ptot_new),
		.divisor  (fill_new),
		.done     (div_p_done),
		.quotient (div_p_q)
	);

	psw_div #(
		.DW (PT_W),
		.VW (FC_W)
	) u_div_spo2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (PT_W'(stot_new)),
		.divisor  (fill_new),
		.done     (div_s_done),
		.quotient (div_s_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			slot_q   <= '0;
			fill_q   <= '0;
			ptot_q   <= '0;
			stot_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (averages.valid && averages.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					ptot_q  <= ptot_new;
					stot_q  <= stot_new;
					fill_q  <= fill_new;
					slot_q  <= slot_new;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_p_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pin_q <= samples.pulse_in;
			sin_q <= samples.spo2_in;
		end
		if (load_out) begin
			pavg_q <= div_p_q[PULSE_W-1:0];
			savg_q <= div_s_q[SPO2_W-1:0];
		end
	end

	assign samples.ready     = state_q == S_IDLE;
	assign averages.valid    = ovalid_q;
	assign averages.pulse_avg = pavg_q;
	assign averages.spo2_avg  = savg_q;

	`PSW_ASSERT_IMP(a_div_lockstep, div_p_done || div_s_done, div_p_done && div_s_done)
	`PSW_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FC_W'(WINDOW))
	`PSW_ASSERT_IMP(a_slot_bound, 1'b1, slot_q <= SLOT_W'(WINDOW - 1))
	`PSW_ASSERT_NXT(a_accept_update, accept, state_q == S_UPD)
endmodule

>>> tb/sv/tb_pulse_spo2_window_average_unit.sv
// ----------------------------------------------------------------------------
// tb_pulse_spo2_window_average_unit
// Self-checking bench for the ten-reading pulse / SpO2 moving average. Readings
// pass through a queue-fed driver with random gaps. A predictor keeps its own
// window and sums and records the expected averages. A monitor with random and
// long output stalls compares every average against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pulse_spo2_window_average_unit import psw_pkg::*; ();

	localparam int WINDOW       = 10;
	localparam int RANDOM_ITEMS = 1680;
	localparam int HOLD_CYCLES  = 250;
	localparam int IDLE_LIMIT   = 3000;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [PULSE_W-1:0] pulse;
		logic [SPO2_W-1:0]  spo2;
		int unsigned        gap;
		bit                 drain;
	} reading_t;

	typedef struct {
		logic [PULSE_W-1:0] pulse_avg;
		logic [SPO2_W-1:0]  spo2_avg;
	} average_t;

	logic clk = 1'b0;
	logic arst_n;

	psw_in_if  samples_ch ();
	psw_out_if averages_ch ();

	reading_t    queued_readings[$];
	average_t    pending_averages[$];

	// predictor state
	logic [PULSE_W-1:0] pulse_window [WINDOW];
	logic [SPO2_W-1:0]  spo2_window  [WINDOW];
	int unsigned        window_slot = 0;
	int unsigned        window_fill = 0;
	int unsigned        pulse_sum   = 0;
	int unsigned        spo2_sum    = 0;

	int unsigned reading_total   = 0;
	int unsigned directed_total  = 0;
	int unsigned readings_sent   = 0;
	int unsigned averages_seen   = 0;
	int unsigned mismatch_count  = 0;
	int unsigned idle_cycles     = 0;
	int unsigned drain_pauses    = 0;

	// driver state
	reading_t    head_reading;
	bit          head_loaded = 1'b0;
	int unsigned head_gap    = 0;

	// monitor state
	int unsigned stall_left  = 0;
	bit          sink_stalls = 1'b1;

	pulse_spo2_window_average_unit #(.WINDOW(WINDOW)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.averages (averages_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_window_average(input logic [PULSE_W-1:0] pulse,
			input logic [SPO2_W-1:0] spo2);
		average_t avg;
		if (window_fill == WINDOW) begin
			pulse_sum -= pulse_window[window_slot];
			spo2_sum  -= spo2_window[window_slot];
		end else begin
			window_fill++;
		end
		pulse_window[window_slot] = pulse;
		spo2_window[window_slot]  = spo2;
		pulse_sum += pulse;
		spo2_sum  += spo2;
		window_slot = (window_slot + 1 == WINDOW) ? 0 : window_slot + 1;
		avg.pulse_avg = PULSE_W'(pulse_sum / window_fill);
		avg.spo2_avg  = SPO2_W'(spo2_sum / window_fill);
		pending_averages.push_back(avg);
	endfunction

	function automatic void add_reading(input int unsigned pulse, input int unsigned spo2,
			input int unsigned gap, input bit drain);
		reading_t r;
		r.pulse = PULSE_W'(pulse);
		r.spo2  = SPO2_W'(spo2);
		r.gap   = gap;
		r.drain = drain;
		queued_readings.push_back(r);
		reading_total++;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_ch.valid    <= 1'b0;
			samples_ch.pulse_in <= '0;
			samples_ch.spo2_in  <= '0;
		end else begin
			if (samples_ch.valid && samples_ch.ready) begin
				predict_window_average(samples_ch.pulse_in, samples_ch.spo2_in);
				readings_sent++;
			end
			if (!samples_ch.valid || samples_ch.ready) begin
				if (!head_loaded && queued_readings.size() > 0) begin
					head_reading = queued_readings.pop_front();
					head_gap     = head_reading.gap;
					head_loaded  = 1'b1;
					if (head_reading.drain)
						drain_pauses++;
				end
				if (head_loaded && head_gap > 0) begin
					head_gap--;
					samples_ch.valid <= 1'b0;
				end else if (head_loaded && head_reading.drain && pending_averages.size() > 0) begin
					samples_ch.valid <= 1'b0;
				end else if (head_loaded) begin
					samples_ch.valid    <= 1'b1;
					samples_ch.pulse_in <= head_reading.pulse;
					samples_ch.spo2_in  <= head_reading.spo2;
					head_loaded = 1'b0;
				end else begin
					samples_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			averages_ch.ready <= 1'b0;
		end else begin
			if (averages_ch.valid && averages_ch.ready) begin
				average_t exp_avg;
				averages_seen++;
				if (pending_averages.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected average: pulse %0d spo2 %0d",
							averages_ch.pulse_avg, averages_ch.spo2_avg);
				end else begin
					exp_avg = pending_averages.pop_front();
					if (averages_ch.pulse_avg !== exp_avg.pulse_avg ||
							averages_ch.spo2_avg !== exp_avg.spo2_avg) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("average %0d: pulse exp %0d got %0d, spo2 exp %0d got %0d",
								averages_seen, exp_avg.pulse_avg, averages_ch.pulse_avg,
								exp_avg.spo2_avg, averages_ch.spo2_avg);
					end
				end
				if (averages_seen % 60 == 0)
					sink_stalls = $urandom_range(0, 2) != 0;
				if (averages_seen == 400 || averages_seen == 1100)
					stall_left = HOLD_CYCLES;
				else
					stall_left = sink_stalls ? $urandom_range(0, 9) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				averages_ch.ready <= 1'b0;
			end else begin
				averages_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_ch.valid && samples_ch.ready) || (averages_ch.valid && averages_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		bit          busy_src;
		int unsigned sel;
		int unsigned p;
		int unsigned s;

		arst_n               = 1'b0;
		samples_ch.valid     = 1'b0;
		samples_ch.pulse_in  = '0;
		samples_ch.spo2_in   = '0;
		averages_ch.ready    = 1'b0;

		// warm-up at full scale, then a full window of zeros to force every subtraction
		for (int i = 0; i < WINDOW; i++)
			add_reading(255, 127, $urandom_range(0, 9), 1'b0);
		for (int i = 0; i < WINDOW; i++)
			add_reading(0, 0, $urandom_range(0, 9), 1'b0);
		add_reading(1, 1, 0, 1'b0);
		add_reading(254, 100, 0, 1'b0);
		add_reading(170, 101, 3, 1'b0);
		add_reading(85, 42, 0, 1'b0);
		directed_total = reading_total;

		busy_src = 1'b1;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 64 == 0)
				busy_src = $urandom_range(0, 2) != 0;
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				p = $urandom_range(0, 1) ? 255 : 0;
				s = $urandom_range(0, 1) ? 127 : 0;
			end else if (sel <= 2) begin
				p = $urandom_range(0, 255);
				s = $urandom_range(0, 127);
			end else begin
				p = $urandom_range(40, 200);
				s = $urandom_range(80, 100);
			end
			add_reading(p, s, busy_src ? $urandom_range(0, 9) : 0,
				(k % 300 == 150) || ($urandom_range(0, 199) == 0));
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (readings_sent < reading_total)
			@(posedge clk);
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (pending_averages.size() != 0) begin
			mismatch_count++;
			$display("%0d averages never arrived", pending_averages.size());
		end
		$display("Sent %0d readings (%0d directed warm-up and wrap cases), checked %0d averages,",
			readings_sent, directed_total, averages_seen);
		$display("with random gaps and stalls, two long output holds and %0d drain pauses; %0d errors.",
			drain_pauses, mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
